// ----- rtl/set_associative_cache_replacement_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the cache replacement block
// Shared shorthand for clocked implications with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOCIATIVE_CACHE_REPLACEMENT_MACROS_SVH
`define SET_ASSOCIATIVE_CACHE_REPLACEMENT_MACROS_SVH

// Same-cycle implication.
`define SCR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define SCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/scr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache replacement package
// Types and fixed constants shared by the cache tag model modules.
// ----------------------------------------------------------------------------
package scr_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_OFFSET_BITS = 2'd0;
  localparam logic [1:0] CFG_SET_BITS    = 2'd1;
  localparam logic [1:0] CFG_WAY_BITS    = 2'd2;
  localparam logic [1:0] CFG_POLICY      = 2'd3;

  // Replacement policy codes; the unused code behaves as tree PLRU.
  localparam logic [1:0] POL_RANDOM = 2'd0;
  localparam logic [1:0] POL_LRU    = 2'd1;
  localparam logic [1:0] POL_PLRU   = 2'd2;

  localparam logic [15:0] LFSR_MASK = 16'hB400;
  localparam logic [15:0] AGE_MAX   = 16'hFFFF;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [4:0] offset_bits;
    logic [3:0] set_bits;
    logic [3:0] way_bits;
    logic [1:0] policy;
  } scr_cfg_t;

  // One block's bookkeeping; the tree bit belongs to node n of the set.
  typedef struct packed {
    logic [31:0] tag;
    logic        valid;
    logic        dirty;
    logic [15:0] age;
    logic        plru;
  } scr_entry_t;

endpackage

// ----- rtl/scr_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache replacement channels
// Access, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface scr_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] address;
  logic        mode;
  modport source (output valid, address, mode, input ready);
  modport sink   (input valid, address, mode, output ready);
endinterface

interface scr_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic        filled_empty;
  logic        dirty_evicted;
  logic [9:0]  way_used;
  logic [31:0] read_miss_total;
  logic [31:0] write_miss_total;
  logic [31:0] dirty_evict_total;
  modport source (output valid, hit, filled_empty, dirty_evicted, way_used,
                  read_miss_total, write_miss_total, dirty_evict_total,
                  input ready);
  modport sink   (input valid, hit, filled_empty, dirty_evicted, way_used,
                  read_miss_total, write_miss_total, dirty_evict_total,
                  output ready);
endinterface

interface scr_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [4:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/scr_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block store
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module scr_ram #(
  parameter int DEPTH  = 1024,
  parameter int IDX_W  = 10,
  parameter int DATA_W = 51
) (
  input  logic              clk,
  input  logic              we,
  input  logic [IDX_W-1:0]  waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [IDX_W-1:0]  raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/scr_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache lookup sequencer
// Walks the ways of one set through the block store: a scan pass for hit,
// free way and oldest way, an optional tree walk, then a read-modify-write
// pass that applies the fill, dirty, age and tree updates.
// ----------------------------------------------------------------------------
module scr_engine #(
  parameter int NUM_BLOCKS = 1024,
  parameter int ADDR_BITS  = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  scr_pkg::scr_cfg_t cfg,
  scr_in_if.sink           in_ch,
  scr_out_if.source        out_ch
);
  import scr_pkg::*;

  localparam int LG    = $clog2(NUM_BLOCKS + 1) - 1;
  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W = LG + 1;
  localparam int W_W   = LG;
  localparam int ENT_W = $bits(scr_entry_t);
  localparam logic [31:0] AMASK =
    (ADDR_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDR_BITS) - 64'd1);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_WALK   = 3'd4;
  localparam logic [2:0] S_WALKD  = 3'd5;
  localparam logic [2:0] S_UPDATE = 3'd6;
  localparam logic [2:0] S_RESULT = 3'd7;

  logic [2:0]       state_r;
  logic [IDX_W:0]   clr_r;
  logic [4:0]       wb_r;
  logic [CNT_W-1:0] ways_r;
  logic [IDX_W-1:0] base_r;
  logic [31:0]      tag_r;
  logic             mode_r;
  logic [1:0]       pol_r;
  logic [CNT_W-1:0] rd_cnt_r;
  logic             rd_vld_r;
  logic [W_W-1:0]   rd_way_r;
  logic             hit_r, empty_r, dev_r;
  logic [W_W-1:0]   hitw_r, emptyw_r, maxw_r, w_r;
  logic [15:0]      maxage_r;
  logic [CNT_W-1:0] node_r;
  logic [15:0]      lfsr_r;
  logic [31:0]      rmiss_r, wmiss_r, devc_r;
  logic [31:0]      rmiss_nxt, wmiss_nxt, devc_nxt;
  logic             out_valid_r;
  logic             o_hit_r, o_empty_r, o_dev_r;
  logic [9:0]       o_way_r;

  // Block store ports.
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  scr_entry_t       ram_wdata, ram_q, ent_new;
  logic [ENT_W-1:0] ram_rdata;

  scr_ram #(.DEPTH(NUM_BLOCKS), .IDX_W(IDX_W), .DATA_W(ENT_W)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );
  assign ram_q = scr_entry_t'(ram_rdata);

  // Address split under the effective geometry.
  logic [4:0]  wb_eff, sb_eff, sb_room;
  logic [31:0] addr_m, set_idx, tag_eff;
  logic [5:0]  tag_sh;
  always_comb begin
    wb_eff  = (5'(cfg.way_bits) < 5'(LG)) ? 5'(cfg.way_bits) : 5'(LG);
    sb_room = 5'(LG) - wb_eff;
    sb_eff  = (5'(cfg.set_bits) < sb_room) ? 5'(cfg.set_bits) : sb_room;
    addr_m  = in_ch.address & AMASK;
    set_idx = (addr_m >> cfg.offset_bits) & ((32'd1 << sb_eff) - 32'd1);
    tag_sh  = 6'(cfg.offset_bits) + 6'(sb_eff);
    tag_eff = addr_m >> tag_sh;
  end

  // Next LFSR value for random replacement.
  logic [15:0] lfsr_step;
  always_comb begin
    lfsr_step = lfsr_r >> 1;
    if (lfsr_r[0]) begin
      lfsr_step = lfsr_step ^ LFSR_MASK;
    end
  end

  // Read-modify-write of one way during the update pass.
  logic [4:0]       node_depth, node_k;
  logic [CNT_W-1:0] path_pos;
  always_comb begin
    node_depth = '0;
    for (int b = 0; b < W_W; b++) begin
      if (rd_way_r[b]) begin
        node_depth = 5'(b);
      end
    end
    node_k   = wb_r - node_depth;
    path_pos = ways_r + CNT_W'(w_r);
    ent_new  = ram_q;
    ent_new.age = (ram_q.age != AGE_MAX) ? ram_q.age + 16'd1 : ram_q.age;
    if (rd_way_r == w_r) begin
      ent_new.age = '0;
      if (!hit_r) begin
        ent_new.valid = 1'b1;
        ent_new.dirty = mode_r;
        ent_new.tag   = tag_r;
      end else if (mode_r) begin
        ent_new.dirty = 1'b1;
      end
    end
    // Nodes on the used way's path point away from it.
    if (rd_way_r != '0 && (path_pos >> node_k) == CNT_W'(rd_way_r)) begin
      ent_new.plru = ((w_r >> (node_k - 5'd1)) & W_W'(1)) == '0;
    end
  end

  // Store address and write selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = IDX_W'(32'(base_r) + 32'(rd_way_r));
    ram_wdata = ent_new;
    ram_raddr = IDX_W'(32'(base_r) + 32'(rd_cnt_r));
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r[IDX_W-1:0];
      ram_wdata = '0;
    end else if (state_r == S_UPDATE && rd_vld_r) begin
      ram_we = 1'b1;
    end
    if (state_r == S_WALK) begin
      ram_raddr = IDX_W'(32'(base_r) + 32'(node_r));
    end
  end

  // Saturating counters for the finished access.
  always_comb begin
    rmiss_nxt = rmiss_r;
    wmiss_nxt = wmiss_r;
    devc_nxt  = devc_r;
    if (!hit_r) begin
      if (mode_r) begin
        wmiss_nxt = (wmiss_r != COUNT_MAX) ? wmiss_r + 32'd1 : wmiss_r;
      end else begin
        rmiss_nxt = (rmiss_r != COUNT_MAX) ? rmiss_r + 32'd1 : rmiss_r;
      end
    end
    if (dev_r) begin
      devc_nxt = (devc_r != COUNT_MAX) ? devc_r + 32'd1 : devc_r;
    end
  end

  logic last_way;
  assign last_way = rd_vld_r && (CNT_W'(rd_way_r) == ways_r - CNT_W'(1));

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      lfsr_r      <= 16'd1;
      rmiss_r     <= '0;
      wmiss_r     <= '0;
      devc_r      <= '0;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
    end else begin
      if (state_r == S_RESULT && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (IDX_W + 1)'(NUM_BLOCKS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            wb_r     <= wb_eff;
            ways_r   <= CNT_W'(1) << wb_eff;
            base_r   <= IDX_W'(set_idx << wb_eff);
            tag_r    <= tag_eff;
            mode_r   <= in_ch.mode;
            pol_r    <= cfg.policy;
            rd_cnt_r <= '0;
            rd_vld_r <= 1'b0;
            hit_r    <= 1'b0;
            empty_r  <= 1'b0;
            dev_r    <= 1'b0;
            state_r  <= S_SCAN;
          end
        end
        S_SCAN, S_UPDATE: begin
          if (last_way) begin
            rd_cnt_r <= '0;
            rd_vld_r <= 1'b0;
            state_r  <= (state_r == S_SCAN) ? S_DECIDE : S_RESULT;
          end else if (rd_cnt_r != ways_r) begin
            rd_cnt_r <= rd_cnt_r + CNT_W'(1);
            rd_vld_r <= 1'b1;
            rd_way_r <= W_W'(rd_cnt_r);
          end else begin
            rd_vld_r <= 1'b0;
          end
          if (state_r == S_SCAN && rd_vld_r) begin
            if (!hit_r && ram_q.valid && ram_q.tag == tag_r) begin
              hit_r  <= 1'b1;
              hitw_r <= rd_way_r;
            end
            if (!empty_r && !ram_q.valid) begin
              empty_r  <= 1'b1;
              emptyw_r <= rd_way_r;
            end
            if (rd_way_r == '0 || ram_q.age > maxage_r) begin
              maxage_r <= ram_q.age;
              maxw_r   <= rd_way_r;
            end
          end
          if (state_r == S_UPDATE && rd_vld_r && rd_way_r == w_r && !hit_r &&
              !empty_r && ram_q.dirty) begin
            dev_r <= 1'b1;
          end
        end
        S_DECIDE: begin
          node_r <= CNT_W'(1);
          if (hit_r) begin
            w_r     <= hitw_r;
            state_r <= S_UPDATE;
          end else if (empty_r) begin
            w_r     <= emptyw_r;
            state_r <= S_UPDATE;
          end else if (ways_r == CNT_W'(1)) begin
            w_r     <= '0;
            state_r <= S_UPDATE;
          end else if (pol_r == POL_RANDOM) begin
            lfsr_r  <= lfsr_step;
            w_r     <= W_W'(32'(lfsr_step) & ((32'd1 << wb_r) - 32'd1));
            state_r <= S_UPDATE;
          end else if (pol_r == POL_LRU) begin
            w_r     <= maxw_r;
            state_r <= S_UPDATE;
          end else begin
            state_r <= S_WALK;
          end
        end
        S_WALK: begin
          state_r <= S_WALKD;
        end
        S_WALKD: begin
          node_r <= {node_r[CNT_W-2:0], ram_q.plru};
          if ({node_r[CNT_W-2:0], ram_q.plru} >= ways_r) begin
            w_r     <= W_W'({node_r[CNT_W-2:0], ram_q.plru} - ways_r);
            state_r <= S_UPDATE;
          end else begin
            state_r <= S_WALK;
          end
        end
        S_RESULT: begin
          if (!out_valid_r || out_ch.ready) begin
            rmiss_r <= rmiss_nxt;
            wmiss_r <= wmiss_nxt;
            devc_r  <= devc_nxt;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (state_r == S_RESULT && (!out_valid_r || out_ch.ready)) begin
      o_hit_r   <= hit_r;
      o_empty_r <= !hit_r && empty_r;
      o_dev_r   <= dev_r;
      o_way_r   <= 10'(32'(w_r));
    end
  end

  assign in_ch.ready              = (state_r == S_IDLE);
  assign out_ch.valid             = out_valid_r;
  assign out_ch.hit               = o_hit_r;
  assign out_ch.filled_empty      = o_empty_r;
  assign out_ch.dirty_evicted     = o_dev_r;
  assign out_ch.way_used          = o_way_r;
  assign out_ch.read_miss_total   = rmiss_r;
  assign out_ch.write_miss_total  = wmiss_r;
  assign out_ch.dirty_evict_total = devc_r;

endmodule

// ----- rtl/set_associative_cache_replacement.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Set-associative cache replacement model
// Write-back, write-allocate tag model with random, LRU and tree PLRU
// replacement, configured through a register write channel.
// ----------------------------------------------------------------------------
// After reset the block sweeps its block store once, one entry per cycle, and
// accepts no access until the sweep is done. Each access walks the set in the
// block store once to search it and once more to write back fill, dirty, age
// and tree bits, with a tree walk between the two on a tree-PLRU replacement.
// One access is in flight at a time; a finished result waits in the output
// register while the next access is taken. Configuration is to be written only
// while the block is idle; the user is bound and the block does not enforce it.
module set_associative_cache_replacement #(
  parameter int NUM_BLOCKS = 1024,
  parameter int ADDR_BITS  = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  scr_in_if.sink    in_ch,
  scr_out_if.source out_ch,
  scr_cfg_if.sink   cfg_ch
);
  import scr_pkg::*;

  scr_cfg_t cfg_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.offset_bits <= 5'd2;
      cfg_r.set_bits    <= 4'd6;
      cfg_r.way_bits    <= 4'd2;
      cfg_r.policy      <= POL_LRU;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_OFFSET_BITS: cfg_r.offset_bits <= cfg_ch.data;
        CFG_SET_BITS:    cfg_r.set_bits    <= cfg_ch.data[3:0];
        CFG_WAY_BITS:    cfg_r.way_bits    <= cfg_ch.data[3:0];
        CFG_POLICY:      cfg_r.policy      <= cfg_ch.data[1:0];
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  scr_engine #(.NUM_BLOCKS(NUM_BLOCKS), .ADDR_BITS(ADDR_BITS)) u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

// ----- rtl/scr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache replacement port checker
// Watches the access and result channels of the top level.
// ----------------------------------------------------------------------------
`include "set_associative_cache_replacement_macros.svh"

module scr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_hit,
  input logic       out_filled_empty,
  input logic       out_dirty_evicted,
  input logic [9:0] out_way_used
);

  // A stalled result beat holds its payload.
  `SCR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_way_used) && $stable(out_hit))

  // A result beat leaves only when taken.
  `SCR_ASSERT_NOW(a_out_drop, clk, rst_n, $fell(out_valid), $past(out_ready))

  // One access at a time: accepting a beat closes the input.
  `SCR_ASSERT_NEXT(a_one_access, clk, rst_n, in_valid && in_ready, !in_ready)

  // A hit neither fills nor evicts.
  `SCR_ASSERT_NOW(a_hit_clean, clk, rst_n, out_valid && out_hit, !out_filled_empty && !out_dirty_evicted)

endmodule

bind set_associative_cache_replacement scr_checker u_scr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_hit           (out_ch.hit),
  .out_filled_empty  (out_ch.filled_empty),
  .out_dirty_evicted (out_ch.dirty_evicted),
  .out_way_used      (out_ch.way_used)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache replacement testbench
// Drives read and write accesses through the set-associative cache tag model
// under several geometries and all replacement policies. A behavioral model
// of the tags, ages, tree bits, LFSR and miss counters predicts every result
// beat, and a checker compares each one field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
  import scr_pkg::*;

  typedef struct {
    bit        hit;
    bit        filled_empty;
    bit        dirty_evicted;
    bit [9:0]  way_used;
    bit [31:0] read_misses;
    bit [31:0] write_misses;
    bit [31:0] dirty_evicts;
  } cache_outcome_t;

  logic clk;
  logic rst_n;

  scr_in_if  in_ch();
  scr_out_if out_ch();
  scr_cfg_if cfg_ch();

  set_associative_cache_replacement dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Shadow of the block's configuration and bookkeeping.
  bit [4:0]  cur_offset;
  bit [3:0]  cur_sets;
  bit [3:0]  cur_ways;
  bit [1:0]  cur_policy;
  bit [31:0] tag_mem [1024];
  bit        valid_mem [1024];
  bit        dirty_mem [1024];
  bit [15:0] age_mem [1024];
  bit        tree_mem [1024];
  bit [15:0] lfsr;
  bit [31:0] rd_miss_cnt;
  bit [31:0] wr_miss_cnt;
  bit [31:0] dirty_cnt;

  cache_outcome_t pending_outcomes[$];

  bit steady;
  int mismatches;
  int accesses_sent;
  int outcomes_seen;
  int hits_seen;
  int dirty_seen;

  // Clock: 12 ns period.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Hard limit on the run, well above the slowest correct run.
  initial begin
    #40_000_000;
    $display("set_associative_cache_replacement: mismatch");
    $finish;
  end

  function automatic bit [31:0] bump(bit [31:0] v);
    return (v == COUNT_MAX) ? v : v + 32'd1;
  endfunction

  // Expected result of one access; updates the shadow state.
  task automatic model_access(input bit [31:0] addr, input bit is_write);
    int unsigned wb, sb, ways, base, way, node, idx;
    bit [63:0] a64;
    bit [31:0] tag;
    bit hit, empty, dev;
    cache_outcome_t res;
    wb = (cur_ways > 10) ? 10 : cur_ways;
    sb = (cur_sets > 10 - wb) ? 10 - wb : cur_sets;
    ways = 1 << wb;
    a64 = {32'd0, addr};
    base = (int'((a64 >> cur_offset) & ((64'd1 << sb) - 1))) << wb;
    tag = 32'(a64 >> (cur_offset + sb));
    hit = 1'b0;
    empty = 1'b0;
    dev = 1'b0;
    way = 0;
    for (idx = 0; idx < ways; idx++) begin
      if (!hit && valid_mem[base + idx] && tag_mem[base + idx] == tag) begin
        hit = 1'b1;
        way = idx;
      end
    end
    if (hit) begin
      if (is_write) dirty_mem[base + way] = 1'b1;
    end else begin
      if (is_write) wr_miss_cnt = bump(wr_miss_cnt);
      else rd_miss_cnt = bump(rd_miss_cnt);
      for (idx = 0; idx < ways; idx++) begin
        if (!empty && !valid_mem[base + idx]) begin
          empty = 1'b1;
          way = idx;
        end
      end
      if (!empty) begin
        // Pick a victim within the set.
        if (ways == 1) begin
          way = 0;
        end else if (cur_policy == POL_RANDOM) begin
          lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_MASK) : (lfsr >> 1);
          way = int'(lfsr) & (ways - 1);
        end else if (cur_policy == POL_LRU) begin
          way = 0;
          for (idx = 1; idx < ways; idx++)
            if (age_mem[base + idx] > age_mem[base + way]) way = idx;
        end else begin
          node = 1;
          while (node < ways) node = 2 * node + tree_mem[base + node];
          way = node - ways;
        end
        if (dirty_mem[base + way]) begin
          dev = 1'b1;
          dirty_cnt = bump(dirty_cnt);
        end
      end
      valid_mem[base + way] = 1'b1;
      dirty_mem[base + way] = is_write;
      tag_mem[base + way] = tag;
    end
    // Age and tree update for the way that was used.
    for (idx = 0; idx < ways; idx++)
      if (age_mem[base + idx] != AGE_MAX) age_mem[base + idx]++;
    age_mem[base + way] = 16'd0;
    node = ways + way;
    while (node > 1) begin
      tree_mem[base + (node >> 1)] = node[0] ? 1'b0 : 1'b1;
      node = node >> 1;
    end
    res.hit = hit;
    res.filled_empty = empty;
    res.dirty_evicted = dev;
    res.way_used = 10'(way);
    res.read_misses = rd_miss_cnt;
    res.write_misses = wr_miss_cnt;
    res.dirty_evicts = dirty_cnt;
    pending_outcomes.push_back(res);
  endtask

  // Send one access beat; valid stays high unless an idle gap follows.
  task automatic send_access(input bit [31:0] addr, input bit is_write);
    in_ch.valid <= 1'b1;
    in_ch.address <= addr;
    in_ch.mode <= is_write;
    do @(posedge clk); while (!in_ch.ready);
    model_access(addr, is_write);
    accesses_sent++;
    if (!steady && $urandom_range(0, 99) < 20) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every expected result has arrived.
  task automatic drain;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one configuration register while the block is idle.
  task automatic write_reg(input logic [1:0] index, input bit [4:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (index)
      CFG_OFFSET_BITS: cur_offset = value;
      CFG_SET_BITS:    cur_sets = value[3:0];
      CFG_WAY_BITS:    cur_ways = value[3:0];
      default:         cur_policy = value[1:0];
    endcase
  endtask

  task automatic set_geometry(input bit [4:0] offs, input bit [4:0] sets,
                              input bit [4:0] ways, input logic [1:0] pol);
    write_reg(CFG_OFFSET_BITS, offs);
    write_reg(CFG_SET_BITS, sets);
    write_reg(CFG_WAY_BITS, ways);
    write_reg(CFG_POLICY, {3'd0, pol});
  endtask

  // Address with a tag from a small pool so that sets fill and hit often.
  function automatic bit [31:0] pool_address(int unsigned tag_pool);
    int unsigned wb, sb;
    bit [63:0] a;
    wb = (cur_ways > 10) ? 10 : cur_ways;
    sb = (cur_sets > 10 - wb) ? 10 - wb : cur_sets;
    if ($urandom_range(0, 99) < 15) return $urandom;
    a = (64'($urandom_range(0, tag_pool)) << (cur_offset + sb))
        | ((64'($urandom) & ((64'd1 << sb) - 1)) << cur_offset)
        | (64'($urandom) & ((64'd1 << cur_offset) - 1));
    return a[31:0];
  endfunction

  // Reset defaults: extremes of the address, hits, fills and evictions.
  task automatic test_default_config;
    int i;
    send_access(32'h0000_0000, 1'b0);
    send_access(32'h0000_0000, 1'b1);
    send_access(32'hFFFF_FFFF, 1'b1);
    send_access(32'hFFFF_FFFF, 1'b0);
    // Six tags in set zero overflow its four ways; writes leave them dirty.
    for (i = 1; i <= 6; i++) send_access(32'(i) << 8, 1'b1);
    send_access(32'h0000_0100, 1'b0);
    send_access(32'h5555_5555, 1'b0);
    send_access(32'hAAAA_AAAA, 1'b1);
    drain();
  endtask

  // Oversized geometry is clamped: fully associative, offset far out.
  task automatic test_geometry_extremes;
    int i;
    set_geometry(5'd31, 5'd31, 5'd15, POL_LRU);
    for (i = 0; i < 6; i++) send_access($urandom, i[0]);
    drain();
    // Direct mapped with no offset or set bits, and the spare policy code.
    set_geometry(5'd0, 5'd0, 5'd0, 2'd3);
    send_access(32'h0000_0001, 1'b1);
    send_access(32'h0000_0002, 1'b0);
    send_access(32'h0000_0001, 1'b0);
    drain();
  endtask

  // Random traffic under one geometry and policy.
  task automatic test_policy(input bit [4:0] offs, input bit [4:0] sets,
                             input bit [4:0] ways, input logic [1:0] pol,
                             input int count);
    int i, pool;
    set_geometry(offs, sets, ways, pol);
    pool = (1 << ((ways > 10) ? 10 : ways)) + 2;
    for (i = 0; i < count; i++)
      send_access(pool_address(pool), $urandom_range(0, 1));
    drain();
  endtask

  // Result checker.
  always @(posedge clk) begin
    cache_outcome_t exp_res;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      outcomes_seen++;
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result beat with no access pending");
      end else begin
        exp_res = pending_outcomes.pop_front();
        if (out_ch.hit !== exp_res.hit || out_ch.filled_empty !== exp_res.filled_empty
            || out_ch.dirty_evicted !== exp_res.dirty_evicted
            || out_ch.way_used !== exp_res.way_used
            || out_ch.read_miss_total !== exp_res.read_misses
            || out_ch.write_miss_total !== exp_res.write_misses
            || out_ch.dirty_evict_total !== exp_res.dirty_evicts) begin
          mismatches++;
          if (mismatches <= 10)
            $display("exp hit %0d fe %0d de %0d way %0d rm %0d wm %0d dm %0d / got %0d %0d %0d %0d %0d %0d %0d",
                     exp_res.hit, exp_res.filled_empty, exp_res.dirty_evicted,
                     exp_res.way_used, exp_res.read_misses, exp_res.write_misses,
                     exp_res.dirty_evicts, out_ch.hit, out_ch.filled_empty,
                     out_ch.dirty_evicted, out_ch.way_used, out_ch.read_miss_total,
                     out_ch.write_miss_total, out_ch.dirty_evict_total);
        end
        if (exp_res.hit) hits_seen++;
        if (exp_res.dirty_evicted) dirty_seen++;
      end
    end
  end

  // Result-side stalls.
  always @(posedge clk) begin
    out_ch.ready <= steady || ($urandom_range(0, 99) >= 20);
  end

  initial begin
    int i;
    in_ch.valid = 1'b0;
    in_ch.address = '0;
    in_ch.mode = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_OFFSET_BITS;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    steady = 1'b0;
    mismatches = 0;
    accesses_sent = 0;
    outcomes_seen = 0;
    hits_seen = 0;
    dirty_seen = 0;
    cur_offset = 5'd2;
    cur_sets = 4'd6;
    cur_ways = 4'd2;
    cur_policy = POL_LRU;
    lfsr = 16'd1;
    rd_miss_cnt = '0;
    wr_miss_cnt = '0;
    dirty_cnt = '0;
    for (i = 0; i < 1024; i++) begin
      tag_mem[i] = '0;
      valid_mem[i] = 1'b0;
      dirty_mem[i] = 1'b0;
      age_mem[i] = '0;
      tree_mem[i] = 1'b0;
    end
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_default_config();
    test_geometry_extremes();
    // State is kept across these changes and read under the new geometry.
    test_policy(5'd2, 5'd3, 5'd2, POL_RANDOM, 250);
    test_policy(5'd4, 5'd2, 5'd3, POL_LRU, 250);
    test_policy(5'd0, 5'd2, 5'd2, POL_PLRU, 250);
    steady = 1'b1;
    test_policy(5'd3, 5'd1, 5'd4, POL_PLRU, 200);
    steady = 1'b0;
    test_policy(5'd16, 5'd4, 5'd1, 2'd3, 150);
    test_policy(5'd1, 5'd0, 5'd3, POL_RANDOM, 150);
    test_policy(5'd5, 5'd10, 5'd0, POL_LRU, 100);
    test_policy(5'd2, 5'd0, 5'd10, POL_RANDOM, 20);

    repeat (50) @(posedge clk);
    $display("Sent %0d accesses, checked %0d results (%0d hits, %0d dirty evictions).",
             accesses_sent, outcomes_seen, hits_seen, dirty_seen);
    $display("Covered all four policy codes, direct mapped to fully associative sets.");
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("set_associative_cache_replacement: match");
    end else begin
      $display("set_associative_cache_replacement: mismatch");
    end
    $finish;
  end

endmodule
